[rtl/pul_pkg.sv]
// ----------------------------------------------------------------------------
// pul_pkg
// Shared types and codes for the positional unique list: list depth,
// operation kinds, result status codes, field widths and the sequencer
// state type.
// ----------------------------------------------------------------------------
package pul_pkg;

  // The position and fill count fields are sized for exactly this depth.
  localparam int DEPTH    = 32;

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int FILL_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SWAP   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_COPY,
    S_PUT,
    S_READ,
    S_READ_WAIT,
    S_SW_A,
    S_SW_B,
    S_SW_C,
    S_SW_D,
    S_RESP
  } state_t;

endpackage

[rtl/pul_in_if.sv]
// ----------------------------------------------------------------------------
// pul_in_if
// Request channel of the positional unique list: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface pul_in_if;
  logic                              valid;
  logic                              ready;
  logic [pul_pkg::KIND_W-1:0]        kind;
  logic [pul_pkg::POS_W-1:0]         position;
  logic [pul_pkg::POS_W-1:0]         other_position;
  logic signed [pul_pkg::VAL_W-1:0]  item_value;

  modport source (output valid, kind, position, other_position, item_value, input ready);
  modport sink (input valid, kind, position, other_position, item_value, output ready);
endinterface

[rtl/pul_out_if.sv]
// ----------------------------------------------------------------------------
// pul_out_if
// Result channel of the positional unique list: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface pul_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pul_pkg::VAL_W-1:0]   read_value;
  logic [pul_pkg::FILL_W-1:0]         fill_count;
  logic                               is_empty;
  logic [pul_pkg::STATUS_W-1:0]       status;

  modport source (output valid, read_value, fill_count, is_empty, status, input ready);
  modport sink (input valid, read_value, fill_count, is_empty, status, output ready);
endinterface

[rtl/pul_store.sv]
// ----------------------------------------------------------------------------
// pul_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pul_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pul_pkg::VAL_W-1:0]   wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pul_pkg::VAL_W-1:0]   rdata
);

  logic [pul_pkg::VAL_W-1:0] mem [DEPTH];
  logic [pul_pkg::VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/positional_unique_list.sv]
// ----------------------------------------------------------------------------
// positional_unique_list
// Packed list of 32-bit values with a fill count, held in one RAM; insert and append refuse duplicates.
// ----------------------------------------------------------------------------
// Usage: one request transaction on in_ch gives exactly one result
// transaction on out_ch. Requests insert, append, delete, modify, read,
// swap or clear. The block works on one request at a time; in_ch.ready is
// high only while the sequencer is idle, so no new request is taken until
// the last one has been through the response state.
// Steps until the result register loads, n the fill count, p the position:
//   insert   a search of all n entries for a duplicate, a shift of the
//            entries from the top down to p, the write and the response
//   append   the same search and an empty shift, then the write at the
//            end of the list and the response
//   delete   a shift of the entries above p down by one, then the response
//   read     a RAM read, the wait for its data, the response; swap
//            reads both entries, writes them back crossed and responds;
//            modify writes and responds; clear and bad positions only respond
// The steps follow from the single RAM port pair: one read and one write
// per cycle. Reset clears the fill count and the sequencer; the entry RAM
// is not cleared, since only entries below the fill count are ever read.
// A waiting result keeps the next request in the response state until
// out_ch.ready frees the output register.
// ----------------------------------------------------------------------------
module positional_unique_list (
  input  logic      clk,
  input  logic      rst_n,
  pul_in_if.sink    in_ch,
  pul_out_if.source out_ch
);

  localparam int DEPTH = pul_pkg::DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (CW > pul_pkg::POS_W) ? CW : pul_pkg::POS_W;

  pul_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [pul_pkg::KIND_W-1:0]      kind_r, kind_nxt;
  logic [CW-1:0]                   tgt_r, tgt_nxt;
  logic [AW-1:0]                   tgt2_r, tgt2_nxt;
  logic [pul_pkg::VAL_W-1:0]       val_r, val_nxt;
  logic [CW-1:0]                   rem_r, rem_nxt;
  logic [AW-1:0]                   src_r, src_nxt;
  logic                            pend_r, pend_nxt;
  logic [AW-1:0]                   pend_src_r, pend_src_nxt;
  logic                            shift_up_r, shift_up_nxt;
  logic                            dup_r, dup_nxt;
  logic [pul_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [pul_pkg::VAL_W-1:0]       rd_r, rd_nxt;
  logic [pul_pkg::VAL_W-1:0]       swap_a_r, swap_a_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [pul_pkg::VAL_W-1:0]       out_value_r, out_value_nxt;
  logic [pul_pkg::FILL_W-1:0]      out_fill_r, out_fill_nxt;
  logic                            out_empty_r, out_empty_nxt;
  logic [pul_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [pul_pkg::VAL_W-1:0]       mem_wdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic [pul_pkg::VAL_W-1:0]       mem_rdata;

  logic [CMPW-1:0]                 in_pos_w;
  logic [CMPW-1:0]                 in_pos2_w;
  logic [CMPW-1:0]                 cnt_w;
  logic [CW-1:0]                   in_pos_c;

  assign in_pos_w  = CMPW'(in_ch.position);
  assign in_pos2_w = CMPW'(in_ch.other_position);
  assign cnt_w     = CMPW'(count_r);
  assign in_pos_c  = CW'(in_ch.position);

  assign in_ch.ready = (state_r == pul_pkg::S_IDLE);

  pul_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pul_pkg::S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tgt_r        <= tgt_nxt;
    tgt2_r       <= tgt2_nxt;
    val_r        <= val_nxt;
    rem_r        <= rem_nxt;
    src_r        <= src_nxt;
    pend_src_r   <= pend_src_nxt;
    shift_up_r   <= shift_up_nxt;
    dup_r        <= dup_nxt;
    status_r     <= status_nxt;
    rd_r         <= rd_nxt;
    swap_a_r     <= swap_a_nxt;
    out_value_r  <= out_value_nxt;
    out_fill_r   <= out_fill_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    kind_nxt       = kind_r;
    tgt_nxt        = tgt_r;
    tgt2_nxt       = tgt2_r;
    val_nxt        = val_r;
    rem_nxt        = rem_r;
    src_nxt        = src_r;
    pend_nxt       = pend_r;
    pend_src_nxt   = pend_src_r;
    shift_up_nxt   = shift_up_r;
    dup_nxt        = dup_r;
    status_nxt     = status_r;
    rd_nxt         = rd_r;
    swap_a_nxt     = swap_a_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_fill_nxt   = out_fill_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = src_r;

    unique case (state_r)
      pul_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt   = in_ch.kind;
          tgt_nxt    = in_pos_c;
          tgt2_nxt   = AW'(in_ch.other_position);
          val_nxt    = in_ch.item_value;
          rd_nxt     = '0;
          status_nxt = pul_pkg::ST_OK;
          rem_nxt    = count_r;
          src_nxt    = '0;
          pend_nxt   = 1'b0;
          dup_nxt    = 1'b0;
          state_nxt  = pul_pkg::S_RESP;
          unique case (in_ch.kind)
            pul_pkg::KIND_INSERT: begin
              if (in_pos_w > cnt_w) begin
                status_nxt = pul_pkg::ST_BADPOS;
              end else begin
                state_nxt = pul_pkg::S_SCAN;
              end
            end
            pul_pkg::KIND_APPEND: begin
              // An append is an insert at the current end of the list.
              tgt_nxt   = count_r;
              state_nxt = pul_pkg::S_SCAN;
            end
            pul_pkg::KIND_DELETE: begin
              if (in_pos_w >= cnt_w) begin
                status_nxt = pul_pkg::ST_BADPOS;
              end else begin
                rem_nxt      = count_r - CW'(1) - in_pos_c;
                src_nxt      = AW'(in_pos_c + CW'(1));
                shift_up_nxt = 1'b0;
                state_nxt    = pul_pkg::S_COPY;
              end
            end
            pul_pkg::KIND_MODIFY: begin
              if (in_pos_w >= cnt_w) begin
                status_nxt = pul_pkg::ST_BADPOS;
              end else begin
                state_nxt = pul_pkg::S_PUT;
              end
            end
            pul_pkg::KIND_READ: begin
              if (in_pos_w >= cnt_w) begin
                status_nxt = pul_pkg::ST_BADPOS;
              end else begin
                state_nxt = pul_pkg::S_READ;
              end
            end
            pul_pkg::KIND_SWAP: begin
              if (in_pos_w >= cnt_w || in_pos2_w >= cnt_w) begin
                status_nxt = pul_pkg::ST_BADPOS;
              end else begin
                state_nxt = pul_pkg::S_SW_A;
              end
            end
            pul_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      pul_pkg::S_SCAN: begin
        // Reads are pipelined: the entry issued last cycle is compared now.
        if (rem_r != '0) begin
          mem_re       = 1'b1;
          src_nxt      = src_r + AW'(1);
          rem_nxt      = rem_r - CW'(1);
          pend_nxt     = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (mem_rdata == val_r)) begin
          dup_nxt = 1'b1;
        end
        if (rem_r == '0 && !pend_r) begin
          if (dup_r) begin
            status_nxt = pul_pkg::ST_DUP;
            state_nxt  = pul_pkg::S_RESP;
          end else if (count_r == CW'(DEPTH)) begin
            status_nxt = pul_pkg::ST_FULL;
            state_nxt  = pul_pkg::S_RESP;
          end else begin
            rem_nxt      = count_r - tgt_r;
            src_nxt      = AW'(count_r - CW'(1));
            shift_up_nxt = 1'b1;
            state_nxt    = pul_pkg::S_COPY;
          end
        end
      end

      pul_pkg::S_COPY: begin
        // Insert moves entries up from the top; delete moves them down.
        if (rem_r != '0) begin
          mem_re       = 1'b1;
          src_nxt      = shift_up_r ? (src_r - AW'(1)) : (src_r + AW'(1));
          rem_nxt      = rem_r - CW'(1);
          pend_nxt     = 1'b1;
          pend_src_nxt = src_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = shift_up_r ? (pend_src_r + AW'(1)) : (pend_src_r - AW'(1));
          mem_wdata = mem_rdata;
        end
        if (rem_r == '0 && !pend_r) begin
          if (shift_up_r) begin
            state_nxt = pul_pkg::S_PUT;
          end else begin
            count_nxt = count_r - CW'(1);
            state_nxt = pul_pkg::S_RESP;
          end
        end
      end

      pul_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(tgt_r);
        mem_wdata = val_r;
        if (kind_r != pul_pkg::KIND_MODIFY) begin
          count_nxt = count_r + CW'(1);
        end
        state_nxt = pul_pkg::S_RESP;
      end

      pul_pkg::S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(tgt_r);
        state_nxt = pul_pkg::S_READ_WAIT;
      end

      pul_pkg::S_READ_WAIT: begin
        rd_nxt    = mem_rdata;
        state_nxt = pul_pkg::S_RESP;
      end

      pul_pkg::S_SW_A: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(tgt_r);
        state_nxt = pul_pkg::S_SW_B;
      end

      pul_pkg::S_SW_B: begin
        mem_re     = 1'b1;
        mem_raddr  = tgt2_r;
        swap_a_nxt = mem_rdata;
        state_nxt  = pul_pkg::S_SW_C;
      end

      pul_pkg::S_SW_C: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(tgt_r);
        mem_wdata = mem_rdata;
        state_nxt = pul_pkg::S_SW_D;
      end

      pul_pkg::S_SW_D: begin
        mem_we    = 1'b1;
        mem_waddr = tgt2_r;
        mem_wdata = swap_a_r;
        state_nxt = pul_pkg::S_RESP;
      end

      pul_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = rd_r;
          out_fill_nxt   = pul_pkg::FILL_W'(count_r);
          out_empty_nxt  = (count_r == '0);
          out_status_nxt = status_r;
          state_nxt      = pul_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pul_pkg::S_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.fill_count = out_fill_r;
  assign out_ch.is_empty   = out_empty_r;
  assign out_ch.status     = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count exceeds the list depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in progress");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pul_pkg::S_IDLE) |-> !mem_we)
    else $error("entry RAM written while the sequencer is idle");

  a_dup_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pul_pkg::S_SCAN && state_nxt == pul_pkg::S_RESP) |=>
      $stable(count_r))
    else $error("rejected insert changed the fill count");

endmodule

[test/tb_positional_unique_list.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_unique_list
// Self-checking testbench for the positional unique list. A short directed
// sequence walks the empty, boundary and duplicate cases. Random requests
// follow; they are generated from the live list state so that they grow the
// list to capacity, shrink it, and mix in noise. Each accepted request is
// predicted in order and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_positional_unique_list;

  localparam int LIST_DEPTH   = pul_pkg::DEPTH;
  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  localparam logic [pul_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [pul_pkg::KIND_W-1:0]        kind;
    logic [pul_pkg::POS_W-1:0]         pos;
    logic [pul_pkg::POS_W-1:0]         pos2;
    logic signed [pul_pkg::VAL_W-1:0]  value;
  } list_req_t;

  typedef struct packed {
    logic signed [pul_pkg::VAL_W-1:0]  read_value;
    logic [pul_pkg::FILL_W-1:0]        fill;
    logic                              is_empty;
    logic [pul_pkg::STATUS_W-1:0]      status;
  } list_result_t;

  typedef struct packed {
    list_req_t    req;
    list_result_t res;
  } reply_entry_t;

  typedef enum int {GEN_GROW, GEN_MIXED, GEN_SHRINK, GEN_NOISE} gen_mode_t;

  logic clk;
  logic rst_n;

  pul_in_if  in_bus ();
  pul_out_if out_bus ();

  positional_unique_list DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Shadow copy of the list, advanced once per accepted request.
  logic [pul_pkg::VAL_W-1:0] list_vals [LIST_DEPTH];
  int                        list_len;

  list_req_t    request_backlog [$];
  reply_entry_t pending_replies [$];

  int  fail_cnt;
  int  sent_cnt;
  int  reply_cnt;
  int  peak_fill;
  int  kind_hits [8];
  int  status_hits [4];
  bit  calm;
  int  tx_gap;
  int  rx_gap;
  int  hold_left;
  bit  hold_done;
  int  cycle_cnt;

  list_req_t    next_req;
  reply_entry_t accepted;
  reply_entry_t oldest;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic list_result_t apply_request(input list_req_t rq);
    list_result_t              res;
    logic [pul_pkg::VAL_W-1:0] tmp;
    bit                        found;
    int                        i;
    int                        p;
    int                        p2;
    res = '0;
    res.status = pul_pkg::ST_OK;
    p = int'(rq.pos);
    p2 = int'(rq.pos2);
    found = 1'b0;
    for (i = 0; i < list_len; i++) begin
      if (list_vals[i] == rq.value) found = 1'b1;
    end
    case (rq.kind)
      pul_pkg::KIND_INSERT: begin
        if (p > list_len) res.status = pul_pkg::ST_BADPOS;
        else if (found) res.status = pul_pkg::ST_DUP;
        else if (list_len >= LIST_DEPTH) res.status = pul_pkg::ST_FULL;
        else begin
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = rq.value;
          list_len++;
        end
      end
      pul_pkg::KIND_APPEND: begin
        if (found) res.status = pul_pkg::ST_DUP;
        else if (list_len >= LIST_DEPTH) res.status = pul_pkg::ST_FULL;
        else begin
          list_vals[list_len] = rq.value;
          list_len++;
        end
      end
      pul_pkg::KIND_DELETE: begin
        if (p >= list_len) res.status = pul_pkg::ST_BADPOS;
        else begin
          for (i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      pul_pkg::KIND_MODIFY: begin
        if (p >= list_len) res.status = pul_pkg::ST_BADPOS;
        else list_vals[p] = rq.value;
      end
      pul_pkg::KIND_READ: begin
        if (p >= list_len) res.status = pul_pkg::ST_BADPOS;
        else res.read_value = list_vals[p];
      end
      pul_pkg::KIND_SWAP: begin
        if (p >= list_len || p2 >= list_len) res.status = pul_pkg::ST_BADPOS;
        else begin
          tmp = list_vals[p];
          list_vals[p] = list_vals[p2];
          list_vals[p2] = tmp;
        end
      end
      pul_pkg::KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    res.fill = list_len[pul_pkg::FILL_W-1:0];
    res.is_empty = (list_len == 0);
    return res;
  endfunction

  function automatic logic [pul_pkg::POS_W-1:0] pick_pos(input int span);
    if (span <= 0) return pul_pkg::POS_W'($urandom_range(0, LIST_DEPTH - 1));
    return pul_pkg::POS_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic [pul_pkg::VAL_W-1:0] fresh_value();
    case ($urandom_range(0, 15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return pul_pkg::VAL_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [pul_pkg::VAL_W-1:0] stored_value();
    if (list_len == 0) return fresh_value();
    return list_vals[$urandom_range(0, list_len - 1)];
  endfunction

  // Requests are drawn against the current shadow state, which may trail
  // the stream by a couple of requests; that only shifts the mix slightly.
  function automatic list_req_t make_request(input gen_mode_t mode);
    list_req_t rq;
    int        r;
    int        span;
    span = (list_len > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : list_len;
    rq.kind = pul_pkg::KIND_READ;
    rq.pos = pick_pos(list_len);
    rq.pos2 = pul_pkg::POS_W'($urandom_range(0, LIST_DEPTH - 1));
    rq.value = $urandom;
    r = $urandom_range(0, 99);
    case (mode)
      GEN_GROW: begin
        if (r < 40) begin
          rq.kind = pul_pkg::KIND_INSERT;
          rq.pos = pul_pkg::POS_W'($urandom_range(0, span));
          rq.value = fresh_value();
        end else if (r < 70) begin
          rq.kind = pul_pkg::KIND_APPEND;
          rq.value = fresh_value();
        end else if (r < 82) begin
          rq.kind = ($urandom_range(0, 1) == 0) ? pul_pkg::KIND_INSERT
                                                : pul_pkg::KIND_APPEND;
          rq.pos = pul_pkg::POS_W'($urandom_range(0, span));
          rq.value = stored_value();
        end else if (r < 88) begin
          rq.kind = pul_pkg::KIND_INSERT;
          rq.pos = pul_pkg::POS_W'($urandom_range(span, LIST_DEPTH - 1));
          rq.value = fresh_value();
        end
      end
      GEN_SHRINK: begin
        if (r < 55) rq.kind = pul_pkg::KIND_DELETE;
        else if (r < 82) begin
          rq.kind = pul_pkg::KIND_SWAP;
          rq.pos2 = pick_pos(list_len);
        end else if (r < 90) begin
          rq.kind = pul_pkg::KIND_MODIFY;
          rq.value = fresh_value();
        end else if (r < 93) rq.kind = pul_pkg::KIND_CLEAR;
        else if (r < 97) begin
          rq.kind = pul_pkg::KIND_DELETE;
          rq.pos = pick_pos(0);
        end
      end
      GEN_MIXED: begin
        rq.kind = (r < 3) ? KIND_UNUSED : pul_pkg::KIND_W'($urandom_range(0, 5));
        if (rq.kind == pul_pkg::KIND_INSERT) begin
          rq.pos = pul_pkg::POS_W'($urandom_range(0, span));
        end
        if (rq.kind == pul_pkg::KIND_SWAP) rq.pos2 = pick_pos(list_len);
        rq.value = ($urandom_range(0, 4) == 0) ? stored_value() : fresh_value();
      end
      default: begin
        rq.kind = pul_pkg::KIND_W'($urandom_range(0, 7));
        rq.pos = pick_pos(0);
      end
    endcase
    return rq;
  endfunction

  task automatic queue_request(input logic [pul_pkg::KIND_W-1:0] kind,
                               input int pos, input int pos2,
                               input logic [pul_pkg::VAL_W-1:0] value);
    list_req_t rq;
    rq.kind = kind;
    rq.pos = pul_pkg::POS_W'(pos);
    rq.pos2 = pul_pkg::POS_W'(pos2);
    rq.value = value;
    request_backlog.push_back(rq);
  endtask

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Request driver: one item is offered at a time and held until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.kind <= pul_pkg::KIND_READ;
      in_bus.position <= '0;
      in_bus.other_position <= '0;
      in_bus.item_value <= '0;
      tx_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        accepted.req.kind = in_bus.kind;
        accepted.req.pos = in_bus.position;
        accepted.req.pos2 = in_bus.other_position;
        accepted.req.value = in_bus.item_value;
        accepted.res = apply_request(accepted.req);
        pending_replies.push_back(accepted);
        kind_hits[accepted.req.kind]++;
        status_hits[accepted.res.status]++;
        if (list_len > peak_fill) peak_fill = list_len;
        sent_cnt++;
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          next_req = request_backlog.pop_front();
          in_bus.kind <= next_req.kind;
          in_bus.position <= next_req.pos;
          in_bus.other_position <= next_req.pos2;
          in_bus.item_value <= next_req.value;
          in_bus.valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 17);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // One long back-pressure window, so the output register fills and the
  // block stops taking requests while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && reply_cnt >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor and receiver-side stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        reply_cnt++;
        if (pending_replies.size() == 0) begin
          note_failure($sformatf("unexpected result read=%0d fill=%0d empty=%0b status=%0d",
                                 out_bus.read_value, out_bus.fill_count,
                                 out_bus.is_empty, out_bus.status));
        end else begin
          oldest = pending_replies.pop_front();
          if (out_bus.read_value !== oldest.res.read_value ||
              out_bus.fill_count !== oldest.res.fill ||
              out_bus.is_empty !== oldest.res.is_empty ||
              out_bus.status !== oldest.res.status) begin
            note_failure({
              $sformatf("kind %0d pos %0d/%0d value %0d: ",
                        oldest.req.kind, oldest.req.pos, oldest.req.pos2,
                        oldest.req.value),
              $sformatf("expected read=%0d fill=%0d empty=%0b status=%0d, ",
                        oldest.res.read_value, oldest.res.fill,
                        oldest.res.is_empty, oldest.res.status),
              $sformatf("got read=%0d fill=%0d empty=%0b status=%0d",
                        out_bus.read_value, out_bus.fill_count,
                        out_bus.is_empty, out_bus.status)});
          end
        end
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) rx_gap <= $urandom_range(1, 17);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d results still outstanding",
             cycle_cnt, pending_replies.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    gen_mode_t mode;
    int        gen_cnt;
    int        seg_left;
    int        r;
    rst_n = 1'b0;
    fail_cnt = 0;
    sent_cnt = 0;
    reply_cnt = 0;
    peak_fill = 0;
    list_len = 0;
    calm = 1'b0;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;

    // Empty list: every positional access is out of range.
    queue_request(pul_pkg::KIND_READ,   0, 0, 32'h0);
    queue_request(pul_pkg::KIND_DELETE, 0, 0, 32'h0);
    queue_request(pul_pkg::KIND_SWAP,   0, 0, 32'h0);
    queue_request(pul_pkg::KIND_INSERT, 1, 0, 32'h1234_5678);
    // Build a small list with the value extremes, inserting at both ends, with duplicates.
    queue_request(pul_pkg::KIND_INSERT, 0, 31, 32'h7FFF_FFFF);
    queue_request(pul_pkg::KIND_APPEND, 31, 31, 32'h8000_0000);
    queue_request(pul_pkg::KIND_APPEND, 0, 0, 32'h7FFF_FFFF);
    queue_request(pul_pkg::KIND_INSERT, 2, 0, 32'hFFFF_FFFF);
    queue_request(pul_pkg::KIND_INSERT, 1, 0, 32'h0);
    queue_request(pul_pkg::KIND_INSERT, 0, 0, 32'h7FFF_FFFF);
    queue_request(pul_pkg::KIND_INSERT, 31, 0, 32'h5);
    // Modify skips the duplicate check and can leave two equal entries.
    queue_request(pul_pkg::KIND_MODIFY, 1, 0, 32'h8000_0000);
    queue_request(pul_pkg::KIND_READ,   1, 0, 32'h0);
    queue_request(pul_pkg::KIND_READ,   3, 0, 32'h0);
    queue_request(pul_pkg::KIND_SWAP,   0, 3, 32'h0);
    queue_request(pul_pkg::KIND_SWAP,   2, 2, 32'h0);
    queue_request(pul_pkg::KIND_SWAP,   0, 31, 32'h0);
    queue_request(pul_pkg::KIND_MODIFY, 4, 0, 32'h1);
    queue_request(pul_pkg::KIND_DELETE, 3, 0, 32'h0);
    queue_request(pul_pkg::KIND_DELETE, 0, 0, 32'h0);
    queue_request(pul_pkg::KIND_READ,   0, 0, 32'h0);
    queue_request(KIND_UNUSED, 31, 31, 32'hFFFF_FFFF);
    queue_request(pul_pkg::KIND_CLEAR,  0, 0, 32'h0);
    queue_request(pul_pkg::KIND_READ,   0, 0, 32'h0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The first segment always grows the list so it reaches capacity early.
    gen_cnt = 0;
    seg_left = 90;
    mode = GEN_GROW;
    while (gen_cnt < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        r = $urandom_range(0, 99);
        mode = (r < 35) ? GEN_GROW : (r < 65) ? GEN_MIXED :
               (r < 90) ? GEN_SHRINK : GEN_NOISE;
        seg_left = $urandom_range(30, 120);
      end
      while (request_backlog.size() >= 2) @(negedge clk);
      request_backlog.push_back(make_request(mode));
      gen_cnt++;
      seg_left--;
      if (gen_cnt >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
    end

    while (request_backlog.size() != 0 || in_bus.valid) @(negedge clk);
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%s%s",
             $sformatf("Covered %0d requests: insert %0d append %0d delete %0d ",
                       sent_cnt, kind_hits[pul_pkg::KIND_INSERT],
                       kind_hits[pul_pkg::KIND_APPEND], kind_hits[pul_pkg::KIND_DELETE]),
             $sformatf("modify %0d read %0d swap %0d clear %0d unused %0d",
                       kind_hits[pul_pkg::KIND_MODIFY], kind_hits[pul_pkg::KIND_READ],
                       kind_hits[pul_pkg::KIND_SWAP], kind_hits[pul_pkg::KIND_CLEAR],
                       kind_hits[KIND_UNUSED]));
    $display("%s%s",
             $sformatf("Status ok %0d duplicate %0d full %0d bad position %0d, ",
                       status_hits[pul_pkg::ST_OK], status_hits[pul_pkg::ST_DUP],
                       status_hits[pul_pkg::ST_FULL], status_hits[pul_pkg::ST_BADPOS]),
             $sformatf("peak fill %0d, %0d results checked", peak_fill, reply_cnt));
    if (fail_cnt == 0 && pending_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_cnt, pending_replies.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
